[design/sta_pkg.sv]
// Package: shared types, codes and constants of the segment table allocator.
package sta_pkg;

    localparam int MEM_BYTES_DEF    = 65536;
    localparam int MAX_SEGMENTS_DEF = 64;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_ACCESS = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [1:0] FIT_FIRST   = 2'd0;
    localparam logic [1:0] FIT_BEST    = 2'd1;
    localparam logic [1:0] FIT_WORST   = 2'd2;
    localparam logic [1:0] FIT_FIRST_B = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_FIT   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NO_ID    = 3'd3;
    localparam logic [2:0] ST_SEGFAULT = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC_CHK,
        S_SHIFT_UP,
        S_SPLIT,
        S_GRANT,
        S_MERGE_RD,
        S_MERGE_HOLD,
        S_MERGE_CHK,
        S_SHIFT_DN,
        S_DONE
    } t_state;

    // one segment table entry; requested size is kept with the entry
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        used;
        logic [15:0] owner;
        logic [16:0] requested;
    } t_entry;

endpackage

[design/segment_table_allocator_core.sv]
// Top level: segment table allocator, one sequencer over one table memory.
//
// Request words enter on i_valid/o_stall: a word is taken at a rising edge with
// i_valid high and o_stall low. o_stall stays high while the word is worked on;
// one result word is then held steady on o_valid until a rising edge with
// i_stall low, and only after that is the next request taken.
// Every step goes through the single table read port, one entry per cycle.
// Steps from the taking edge until o_valid rises:
//   allocate: scan (stopping early for first fit), check, then, if the pick
//   is split, shift the entries above it up one and write the remainder;
//   last write the pick.
//   free: scan for the id, then one walk merging free neighbors; each of the
//   at most two merges shifts the tail down.
//   access: scan until a used segment holds the address.
//   unknown type: straight to the result, with no table step.
// A stalled result holds the block; nothing is lost or reordered.
// Reset clears the table, entry 0 becoming one free segment of MEM_BYTES;
// o_stall is high during the clearing pass. fit_policy is written through
// i_cfg_we/i_cfg_data, by the user only while no word is in flight; the block
// does not enforce it. Counters saturate at 2^32-1, reported with every result.
module segment_table_allocator_core #(
    parameter int MEM_BYTES    = sta_pkg::MEM_BYTES_DEF,
    parameter int MAX_SEGMENTS = sta_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [16:0] i_request_size,
    input  logic [15:0] i_target_id,
    input  logic [15:0] i_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_granted_id,
    output logic [15:0] o_granted_start,
    output logic [16:0] o_granted_size,
    output logic [31:0] o_success_count,
    output logic [31:0] o_fail_count
);
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

    sta_pkg::t_state r_state, n_state;
    logic [1:0]  r_fit;
    logic [1:0]  r_type;
    logic [16:0] r_req;
    logic [31:0] r_aligned;
    logic [15:0] r_id, r_addr;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_pick, n_pick;
    logic        r_found, n_found;
    logic [31:0] r_psize, n_psize;
    logic [15:0] r_next_id, n_next_id;
    logic [31:0] r_ok, n_ok, r_bad, n_bad;
    logic [2:0]  r_status, n_status;
    logic [15:0] r_gid, n_gid, r_gstart, n_gstart;
    logic [16:0] r_gsize, n_gsize;
    logic        r_clr;
    logic [CW-1:0] r_clr_idx;
    sta_pkg::t_entry r_hold, n_hold;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    sta_pkg::t_entry wdata, rdata, init_entry;

    logic          take, scan_end, fits, better, first_fit, id_hit, addr_hit;
    logic          split, has_tail, both_free, hold_end, pair_end, tail_end;
    logic [31:0]   seg_end;

    sta_table #(.MAX_SEGMENTS(MAX_SEGMENTS), .AW(AW)) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_stall = r_clr || (r_state != sta_pkg::S_IDLE);
    assign o_valid = (r_state == sta_pkg::S_DONE);
    assign o_status = r_status;
    assign o_granted_id = r_gid;
    assign o_granted_start = r_gstart;
    assign o_granted_size = r_gsize;
    assign o_success_count = r_ok;
    assign o_fail_count = r_bad;

    assign take = i_valid && !o_stall;
    assign scan_end = (r_idx >= r_count);
    assign seg_end = rdata.start + rdata.size;
    assign fits = !rdata.used && (rdata.size >= r_aligned);
    assign first_fit = (r_fit == sta_pkg::FIT_FIRST) || (r_fit == sta_pkg::FIT_FIRST_B);
    assign better = fits && (!r_found ||
                    (r_fit == sta_pkg::FIT_BEST && rdata.size < r_psize) ||
                    (r_fit == sta_pkg::FIT_WORST && rdata.size > r_psize));
    assign id_hit = rdata.used && (rdata.owner == r_id);
    assign addr_hit = rdata.used && ({16'd0, r_addr} >= rdata.start) &&
                      ({16'd0, r_addr} < seg_end);
    assign split = (r_psize > r_aligned);
    assign has_tail = (r_count - CW'(1) > r_pick);
    assign both_free = !r_hold.used && !rdata.used;
    assign hold_end = (r_idx + CW'(1) >= r_count);
    assign pair_end = (r_idx + CW'(2) >= r_count);
    assign tail_end = (r_ptr + CW'(1) >= r_count);

    always_comb begin
        init_entry = '0;
        init_entry.size = 32'(MEM_BYTES);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sta_pkg::S_IDLE: begin
                if (take) begin
                    n_state = (i_req_type == sta_pkg::REQ_NONE) ? sta_pkg::S_DONE
                                                                 : sta_pkg::S_SCAN;
                end
            end
            sta_pkg::S_SCAN: begin
                priority if (scan_end) begin
                    n_state = (r_type == sta_pkg::REQ_ALLOC) ? sta_pkg::S_ALLOC_CHK
                                                             : sta_pkg::S_DONE;
                end else if (r_type == sta_pkg::REQ_ALLOC) begin
                    if (fits && first_fit) begin
                        n_state = sta_pkg::S_ALLOC_CHK;
                    end
                end else if (r_type == sta_pkg::REQ_FREE) begin
                    if (id_hit) begin
                        n_state = sta_pkg::S_MERGE_RD;
                    end
                end else if (addr_hit) begin
                    n_state = sta_pkg::S_DONE;
                end
            end
            sta_pkg::S_ALLOC_CHK: begin
                priority if (!r_found) begin
                    n_state = sta_pkg::S_DONE;
                end else if (split && r_count >= MAXC) begin
                    n_state = sta_pkg::S_DONE;
                end else if (split && has_tail) begin
                    n_state = sta_pkg::S_SHIFT_UP;
                end else if (split) begin
                    n_state = sta_pkg::S_SPLIT;
                end else begin
                    n_state = sta_pkg::S_GRANT;
                end
            end
            sta_pkg::S_SHIFT_UP: begin
                if (r_ptr == r_pick + CW'(1)) begin
                    n_state = sta_pkg::S_SPLIT;
                end
            end
            sta_pkg::S_SPLIT:    n_state = sta_pkg::S_GRANT;
            sta_pkg::S_GRANT:    n_state = sta_pkg::S_DONE;
            sta_pkg::S_MERGE_RD: n_state = sta_pkg::S_MERGE_HOLD;
            sta_pkg::S_MERGE_HOLD: begin
                n_state = hold_end ? sta_pkg::S_DONE : sta_pkg::S_MERGE_CHK;
            end
            sta_pkg::S_MERGE_CHK: begin
                priority if (pair_end) begin
                    n_state = sta_pkg::S_DONE;
                end else if (both_free) begin
                    n_state = sta_pkg::S_SHIFT_DN;
                end
            end
            sta_pkg::S_SHIFT_DN: begin
                if (tail_end) begin
                    n_state = sta_pkg::S_MERGE_RD;
                end
            end
            sta_pkg::S_DONE: begin
                if (!i_stall) begin
                    n_state = sta_pkg::S_IDLE;
                end
            end
            default: n_state = sta_pkg::S_IDLE;
        endcase
    end

    // datapath and table port
    always_comb begin
        n_count = r_count;
        n_idx = r_idx;
        n_ptr = r_ptr;
        n_pick = r_pick;
        n_found = r_found;
        n_psize = r_psize;
        n_next_id = r_next_id;
        n_ok = r_ok;
        n_bad = r_bad;
        n_status = r_status;
        n_gid = r_gid;
        n_gstart = r_gstart;
        n_gsize = r_gsize;
        n_hold = r_hold;
        we = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = rdata;
        raddr = r_idx[AW-1:0];
        unique case (r_state)
            sta_pkg::S_IDLE: begin
                raddr = '0;
                if (take) begin
                    n_idx = '0;
                    n_found = 1'b0;
                    n_status = sta_pkg::ST_OK;
                    n_gid = '0;
                    n_gstart = '0;
                    n_gsize = '0;
                end
            end
            sta_pkg::S_SCAN: begin
                // rdata holds entry r_idx
                raddr = AW'(r_idx + CW'(1));
                n_idx = r_idx + CW'(1);
                priority if (scan_end) begin
                    if (r_type == sta_pkg::REQ_FREE) begin
                        n_status = sta_pkg::ST_NO_ID;
                    end else if (r_type == sta_pkg::REQ_ACCESS) begin
                        n_status = sta_pkg::ST_SEGFAULT;
                    end
                end else if (r_type == sta_pkg::REQ_ALLOC) begin
                    if (better) begin
                        n_pick = r_idx;
                        n_psize = rdata.size;
                        n_hold = rdata;
                    end
                    if (fits) begin
                        n_found = 1'b1;
                    end
                end else if (r_type == sta_pkg::REQ_FREE) begin
                    if (id_hit) begin
                        we = 1'b1;
                        wdata.used = 1'b0;
                        wdata.owner = '0;
                        n_idx = '0;
                    end
                end
            end
            sta_pkg::S_ALLOC_CHK: begin
                priority if (!r_found) begin
                    n_status = sta_pkg::ST_NO_FIT;
                    n_bad = (r_bad == '1) ? r_bad : r_bad + 32'd1;
                end else if (split && r_count >= MAXC) begin
                    n_status = sta_pkg::ST_FULL;
                    n_bad = (r_bad == '1) ? r_bad : r_bad + 32'd1;
                end else begin
                    n_ptr = r_count - CW'(1);
                    raddr = AW'(r_count - CW'(1));
                end
            end
            sta_pkg::S_SHIFT_UP: begin
                // rdata holds entry r_ptr; it moves up one
                we = 1'b1;
                waddr = AW'(r_ptr + CW'(1));
                wdata = rdata;
                raddr = AW'(r_ptr - CW'(1));
                n_ptr = r_ptr - CW'(1);
            end
            sta_pkg::S_SPLIT: begin
                we = 1'b1;
                waddr = AW'(r_pick + CW'(1));
                wdata = '0;
                wdata.start = r_hold.start + r_aligned;
                wdata.size = r_psize - r_aligned;
                n_count = r_count + CW'(1);
            end
            sta_pkg::S_GRANT: begin
                we = 1'b1;
                waddr = r_pick[AW-1:0];
                wdata = '0;
                wdata.start = r_hold.start;
                wdata.size = r_aligned;
                wdata.used = 1'b1;
                wdata.owner = r_next_id;
                wdata.requested = r_req;
                n_gid = r_next_id;
                n_gstart = r_hold.start[15:0];
                n_gsize = r_aligned[16:0];
                n_next_id = (r_next_id == 16'hFFFF) ? 16'd1 : r_next_id + 16'd1;
                n_ok = (r_ok == '1) ? r_ok : r_ok + 32'd1;
            end
            sta_pkg::S_MERGE_RD: begin
                raddr = r_idx[AW-1:0];
            end
            sta_pkg::S_MERGE_HOLD: begin
                n_hold = rdata;
                raddr = AW'(r_idx + CW'(1));
            end
            sta_pkg::S_MERGE_CHK: begin
                // r_hold is entry r_idx, rdata is entry r_idx+1
                raddr = AW'(r_idx + CW'(2));
                if (both_free) begin
                    we = 1'b1;
                    wdata = r_hold;
                    wdata.size = r_hold.size + rdata.size;
                    n_hold = wdata;
                    n_ptr = r_idx + CW'(2);
                    if (pair_end) begin
                        n_count = r_count - CW'(1);
                    end
                end else begin
                    n_hold = rdata;
                    n_idx = r_idx + CW'(1);
                end
            end
            sta_pkg::S_SHIFT_DN: begin
                // rdata holds entry r_ptr; it moves down one
                we = 1'b1;
                waddr = AW'(r_ptr - CW'(1));
                wdata = rdata;
                raddr = AW'(r_ptr + CW'(1));
                n_ptr = r_ptr + CW'(1);
                if (tail_end) begin
                    n_count = r_count - CW'(1);
                end
            end
            sta_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
        if (r_clr) begin
            we = 1'b1;
            waddr = r_clr_idx[AW-1:0];
            wdata = (r_clr_idx == '0) ? init_entry : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sta_pkg::S_IDLE;
            r_fit <= sta_pkg::FIT_FIRST;
            r_count <= CW'(1);
            r_next_id <= 16'd1;
            r_ok <= '0;
            r_bad <= '0;
            r_clr <= 1'b1;
            r_clr_idx <= '0;
        end else begin
            if (i_cfg_we) begin
                r_fit <= i_cfg_data;
            end
            if (r_clr) begin
                r_clr_idx <= r_clr_idx + CW'(1);
                if (r_clr_idx == MAXC - CW'(1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_state <= n_state;
            r_count <= n_count;
            r_next_id <= n_next_id;
            r_ok <= n_ok;
            r_bad <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_ptr <= n_ptr;
        r_pick <= n_pick;
        r_found <= n_found;
        r_psize <= n_psize;
        r_status <= n_status;
        r_gid <= n_gid;
        r_gstart <= n_gstart;
        r_gsize <= n_gsize;
        r_hold <= n_hold;
        if (take) begin
            r_type <= i_req_type;
            r_req <= i_request_size;
            r_aligned <= ({15'd0, i_request_size} + 32'd3) & ~32'd3;
            r_id <= i_target_id;
            r_addr <= i_address;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= MAXC)
        else $error("segment count out of range");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result shown while accepting");
    a_ok_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == sta_pkg::ST_OK && r_type == sta_pkg::REQ_ALLOC)
        |-> o_granted_id != '0)
        else $error("zero id granted");
    a_clr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> r_state == sta_pkg::S_IDLE)
        else $error("request worked on during clearing pass");
`endif
endmodule

[design/sta_table.sv]
// Segment table memory: one write port, one registered read port.
module sta_table #(
    parameter int MAX_SEGMENTS = sta_pkg::MAX_SEGMENTS_DEF,
    parameter int AW           = $clog2(MAX_SEGMENTS)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  sta_pkg::t_entry   i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output sta_pkg::t_entry   o_rdata
);
    sta_pkg::t_entry r_mem [MAX_SEGMENTS];
    sta_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[bench/tb_segment_table_allocator_core.sv]
// Testbench: segment_table_allocator_core checked word by word against a predictor of the table.
`timescale 1ns / 1ps

module tb_segment_table_allocator_core;

    localparam int NSEG = sta_pkg::MAX_SEGMENTS_DEF;
    localparam int MEMB = sta_pkg::MEM_BYTES_DEF;
    localparam int DRAIN_CYCLES = 2 * NSEG + 20;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] gid;
        logic [15:0] gstart;
        logic [16:0] gsize;
        logic [31:0] ok_cnt;
        logic [31:0] bad_cnt;
    } t_word;

    typedef struct packed {
        logic [1:0]  rtype;
        logic [16:0] size;
        logic [15:0] id;
        logic [15:0] addr;
        logic        typed;
        logic [2:0]  status;
        logic [15:0] gid;
        logic [15:0] gstart;
        logic [16:0] gsize;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type = '0;
    logic [16:0] i_request_size = '0;
    logic [15:0] i_target_id = '0;
    logic [15:0] i_address = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_granted_id;
    logic [15:0] o_granted_start;
    logic [16:0] o_granted_size;
    logic [31:0] o_success_count;
    logic [31:0] o_fail_count;

    segment_table_allocator_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_request_size(i_request_size),
        .i_target_id(i_target_id), .i_address(i_address),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_granted_id(o_granted_id),
        .o_granted_start(o_granted_start), .o_granted_size(o_granted_size),
        .o_success_count(o_success_count), .o_fail_count(o_fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted segment table
    int          seg_base [NSEG];
    int          seg_len [NSEG];
    bit          seg_busy [NSEG];
    logic [15:0] seg_id [NSEG];
    logic [16:0] seg_asked [NSEG];
    int          seg_n;
    logic [15:0] id_next;
    logic [31:0] grant_total;
    logic [31:0] refuse_total;
    logic [1:0]  fit_mode;

    t_word expected_words[$];
    int errors = 0;
    int words_checked = 0;
    int status_seen [8];
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_arm = 1'b0;
    bit hold_fired = 1'b0;
    int hold_left = 0;

    task automatic clear_seg(input int k);
        seg_base[k] = 0; seg_len[k] = 0; seg_busy[k] = 0;
        seg_id[k] = '0; seg_asked[k] = '0;
    endtask

    task automatic table_reset();
        for (int k = 0; k < NSEG; k++) clear_seg(k);
        seg_len[0] = MEMB;
        seg_n = 1;
        id_next = 16'd1;
        grant_total = '0;
        refuse_total = '0;
        fit_mode = sta_pkg::FIT_FIRST;
    endtask

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    task automatic copy_seg(input int dst, input int src);
        seg_base[dst] = seg_base[src]; seg_len[dst] = seg_len[src];
        seg_busy[dst] = seg_busy[src]; seg_id[dst] = seg_id[src];
        seg_asked[dst] = seg_asked[src];
    endtask

    task automatic predict_request(input logic [1:0] rtype, input logic [16:0] req,
                                   input logic [15:0] id, input logic [15:0] addr,
                                   output t_word w);
        int aligned;
        int pick;
        bit found;
        int k;
        w = '0;
        if (rtype == sta_pkg::REQ_ALLOC) begin
            aligned = (int'(req) + 3) & ~3;
            found = 0;
            pick = 0;
            for (k = 0; k < seg_n; k++) begin
                if (seg_busy[k] || seg_len[k] < aligned) continue;
                if (!found) begin
                    found = 1;
                    pick = k;
                    if (fit_mode == sta_pkg::FIT_FIRST || fit_mode == sta_pkg::FIT_FIRST_B)
                        break;
                    continue;
                end
                if (fit_mode == sta_pkg::FIT_BEST && seg_len[k] < seg_len[pick]) pick = k;
                if (fit_mode == sta_pkg::FIT_WORST && seg_len[k] > seg_len[pick]) pick = k;
            end
            if (!found) begin
                refuse_total = sat_inc(refuse_total);
                w.status = sta_pkg::ST_NO_FIT;
            end else if (seg_len[pick] > aligned && seg_n >= NSEG) begin
                refuse_total = sat_inc(refuse_total);
                w.status = sta_pkg::ST_FULL;
            end else begin
                if (seg_len[pick] > aligned) begin
                    for (k = seg_n; k > pick + 1; k--) copy_seg(k, k - 1);
                    seg_base[pick + 1] = seg_base[pick] + aligned;
                    seg_len[pick + 1] = seg_len[pick] - aligned;
                    seg_busy[pick + 1] = 0;
                    seg_id[pick + 1] = '0;
                    seg_asked[pick + 1] = '0;
                    seg_len[pick] = aligned;
                    seg_n++;
                end
                seg_busy[pick] = 1;
                seg_id[pick] = id_next;
                seg_asked[pick] = req;
                id_next = (id_next == 16'hFFFF) ? 16'd1 : id_next + 16'd1;
                grant_total = sat_inc(grant_total);
                w.status = sta_pkg::ST_OK;
                w.gid = seg_id[pick];
                w.gstart = seg_base[pick][15:0];
                w.gsize = seg_len[pick][16:0];
            end
        end else if (rtype == sta_pkg::REQ_FREE) begin
            found = 0;
            for (k = 0; k < seg_n; k++) begin
                if (seg_busy[k] && seg_id[k] == id) begin
                    seg_busy[k] = 0;
                    seg_id[k] = '0;
                    found = 1;
                    break;
                end
            end
            if (!found) begin
                w.status = sta_pkg::ST_NO_ID;
            end else begin
                k = 0;
                while (k + 1 < seg_n) begin
                    if (!seg_busy[k] && !seg_busy[k + 1]) begin
                        seg_len[k] += seg_len[k + 1];
                        for (int m = k + 1; m + 1 < seg_n; m++) copy_seg(m, m + 1);
                        seg_n--;
                        clear_seg(seg_n);
                    end else begin
                        k++;
                    end
                end
                w.status = sta_pkg::ST_OK;
            end
        end else if (rtype == sta_pkg::REQ_ACCESS) begin
            w.status = sta_pkg::ST_SEGFAULT;
            for (k = 0; k < seg_n; k++) begin
                if (seg_busy[k] && int'(addr) >= seg_base[k] &&
                    int'(addr) < seg_base[k] + seg_len[k]) begin
                    w.status = sta_pkg::ST_OK;
                    break;
                end
            end
        end
        w.ok_cnt = grant_total;
        w.bad_cnt = refuse_total;
    endtask

    // call right after a rising edge; returns at the edge where the word is taken, or after a random idle gap
    task automatic send_word(input logic [1:0] rtype, input logic [16:0] req,
                             input logic [15:0] id, input logic [15:0] addr,
                             output t_word w);
        i_valid <= 1'b1;
        i_req_type <= rtype;
        i_request_size <= req;
        i_target_id <= id;
        i_address <= addr;
        do @(posedge i_clk); while (o_stall);
        predict_request(rtype, req, id, addr, w);
        expected_words.push_back(w);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain_and_write(input logic [1:0] policy);
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= policy;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fit_mode = policy;
    endtask

    function automatic logic [15:0] live_id();
        int hits [$];
        for (int k = 0; k < seg_n; k++) if (seg_busy[k]) hits.push_back(k);
        if (hits.size() == 0) return 16'd0;
        return seg_id[hits[$urandom_range(hits.size() - 1)]];
    endfunction

    function automatic logic [15:0] addr_near_segment();
        int k;
        k = $urandom_range(seg_n - 1);
        return 16'(seg_base[k] + $urandom_range(0, 7) - 2);
    endfunction

    task automatic random_word(output t_word w);
        int pick;
        logic [16:0] sz;
        pick = $urandom_range(99);
        if (pick < 50) begin
            case ($urandom_range(9))
                0: sz = 17'($urandom_range(0, 131071));
                1: sz = 17'($urandom_range(8192, 40000));
                default: sz = 17'($urandom_range(0, 1200));
            endcase
            send_word(sta_pkg::REQ_ALLOC, sz, 16'($urandom), 16'($urandom), w);
        end else if (pick < 75) begin
            send_word(sta_pkg::REQ_FREE, 17'($urandom),
                      ($urandom_range(9) < 8) ? live_id() : 16'($urandom),
                      16'($urandom), w);
        end else if (pick < 95) begin
            send_word(sta_pkg::REQ_ACCESS, 17'($urandom), 16'($urandom),
                      ($urandom_range(1)) ? addr_near_segment() : 16'($urandom), w);
        end else begin
            send_word(sta_pkg::REQ_NONE, 17'($urandom), 16'($urandom), 16'($urandom), w);
        end
    endtask

    // long receiver hold, counted in cycles
    always @(posedge i_clk) begin
        if (hold_arm && !hold_fired) begin
            hold_left <= 600;
            hold_fired <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result side: check each taken word, then pick the next stall
    always @(posedge i_clk) begin
        t_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: status %0d", o_status);
                errors++;
            end else begin
                e = expected_words.pop_front();
                words_checked++;
                status_seen[o_status]++;
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_granted_id !== e.gid) begin
                    $error("granted_id exp %0d got %0d", e.gid, o_granted_id); errors++;
                end
                if (o_granted_start !== e.gstart) begin
                    $error("granted_start exp %0d got %0d", e.gstart, o_granted_start);
                    errors++;
                end
                if (o_granted_size !== e.gsize) begin
                    $error("granted_size exp %0d got %0d", e.gsize, o_granted_size);
                    errors++;
                end
                if (o_success_count !== e.ok_cnt) begin
                    $error("success_count exp %0d got %0d", e.ok_cnt, o_success_count);
                    errors++;
                end
                if (o_fail_count !== e.bad_cnt) begin
                    $error("fail_count exp %0d got %0d", e.bad_cnt, o_fail_count);
                    errors++;
                end
            end
        end
        i_stall <= (hold_left > 0) ||
                   ((rx_idle_pct > 0) && ($urandom_range(99) < rx_idle_pct));
    end

    initial begin
        #40ms;
        $display("segment_table_allocator_core regression: fail");
        $finish;
    end

    t_dir_row dir_rows [14];
    logic [1:0] policies [4];

    initial begin
        t_word w;
        dir_rows = '{
            '{sta_pkg::REQ_ACCESS, 17'd0, 16'd0, 16'd0, 1'b1,
              sta_pkg::ST_SEGFAULT, 16'd0, 16'd0, 17'd0},
            '{sta_pkg::REQ_FREE, 17'd0, 16'd0, 16'd0, 1'b1,
              sta_pkg::ST_NO_ID, 16'd0, 16'd0, 17'd0},
            '{sta_pkg::REQ_ALLOC, 17'd0, 16'd0, 16'd0, 1'b1,
              sta_pkg::ST_OK, 16'd1, 16'd0, 17'd0},
            '{sta_pkg::REQ_ALLOC, 17'd1, 16'd0, 16'd0, 1'b1,
              sta_pkg::ST_OK, 16'd2, 16'd0, 17'd4},
            '{sta_pkg::REQ_ALLOC, 17'd65536, 16'd0, 16'd0, 1'b1,
              sta_pkg::ST_NO_FIT, 16'd0, 16'd0, 17'd0},
            '{sta_pkg::REQ_ALLOC, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
              sta_pkg::ST_NO_FIT, 16'd0, 16'd0, 17'd0},
            '{sta_pkg::REQ_ALLOC, 17'd5, 16'd0, 16'd0, 1'b1,
              sta_pkg::ST_OK, 16'd3, 16'd4, 17'd8},
            '{sta_pkg::REQ_ACCESS, 17'd0, 16'd0, 16'd4, 1'b1,
              sta_pkg::ST_OK, 16'd0, 16'd0, 17'd0},
            '{sta_pkg::REQ_ACCESS, 17'd0, 16'd0, 16'd12, 1'b1,
              sta_pkg::ST_SEGFAULT, 16'd0, 16'd0, 17'd0},
            '{sta_pkg::REQ_FREE, 17'd0, 16'd2, 16'd0, 1'b1,
              sta_pkg::ST_OK, 16'd0, 16'd0, 17'd0},
            '{sta_pkg::REQ_FREE, 17'd0, 16'd2, 16'd0, 1'b1,
              sta_pkg::ST_NO_ID, 16'd0, 16'd0, 17'd0},
            '{sta_pkg::REQ_ALLOC, 17'd65524, 16'd0, 16'd0, 1'b1,
              sta_pkg::ST_OK, 16'd4, 16'd12, 17'd65524},
            '{sta_pkg::REQ_ACCESS, 17'd0, 16'd0, 16'hFFFF, 1'b1,
              sta_pkg::ST_OK, 16'd0, 16'd0, 17'd0},
            '{sta_pkg::REQ_NONE, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 1'b0,
              sta_pkg::ST_OK, 16'd0, 16'd0, 17'd0}
        };
        policies = '{sta_pkg::FIT_FIRST_B, sta_pkg::FIT_BEST, sta_pkg::FIT_WORST,
                     sta_pkg::FIT_FIRST};
        table_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drain_and_write(sta_pkg::FIT_FIRST);

        foreach (dir_rows[r]) begin
            send_word(dir_rows[r].rtype, dir_rows[r].size, dir_rows[r].id,
                      dir_rows[r].addr, w);
            if (dir_rows[r].typed && {w.status, w.gid, w.gstart, w.gsize} !==
                {dir_rows[r].status, dir_rows[r].gid, dir_rows[r].gstart,
                 dir_rows[r].gsize}) begin
                $error("directed row %0d: prediction %0d/%0d/%0d/%0d off the table", r,
                       w.status, w.gid, w.gstart, w.gsize);
                errors++;
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain_and_write(policies[ph]);
            case (ph)
                0: begin tx_idle_pct = 34; rx_idle_pct = 73; end
                1: begin tx_idle_pct = 73; rx_idle_pct = 34; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (ph == 2) hold_arm = 1'b1;
            for (int n = 0; n < 250; n++) random_word(w);
            // free up to 30 live segments so the next policy starts from a mixed table
            if (ph < 3) begin
                for (int n = 0; n < 30; n++)
                    send_word(sta_pkg::REQ_FREE, '0, live_id(), '0, w);
            end
        end

        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d result words: ok %0d, no fit %0d, table full %0d",
                 words_checked, status_seen[sta_pkg::ST_OK], status_seen[sta_pkg::ST_NO_FIT],
                 status_seen[sta_pkg::ST_FULL]);
        $display("id not found %0d, segfault %0d, all four fit policies exercised",
                 status_seen[sta_pkg::ST_NO_ID], status_seen[sta_pkg::ST_SEGFAULT]);
        if (errors == 0) begin
            $display("segment_table_allocator_core regression: pass");
        end else begin
            $display("segment_table_allocator_core regression: fail");
        end
        $finish;
    end

endmodule

[segment_table_allocator_core.f]
design/sta_pkg.sv
design/sta_table.sv
design/segment_table_allocator_core.sv
bench/tb_segment_table_allocator_core.sv
